>>> src/sha_pkg.sv
// Shared types, constants and a rotate function for the SHA-256 byte hasher.
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueueAw    = $clog2(QueueDepth);

    localparam logic [31:0] PadWord = 32'h80000000;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> src/sha_in_queue.sv
// Input word queue between the handshake front and the hashing core.
module sha_in_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sha_pkg::t_in_word i_word,
    output logic              o_full,
    output logic              o_valid,
    output sha_pkg::t_in_word o_word,
    input  logic              i_take
);
    import sha_pkg::*;

    t_in_word r_mem [QueueDepth];
    logic [QueueAw-1:0] r_wr, r_rd;
    logic [QueueAw:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (QueueAw+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QueueAw+1)'(do_push) - (QueueAw+1)'(do_pop);
        end
    end
endmodule

>>> src/sha_core.sv
// Byte packing, padding, round-per-cycle compression and digest output.
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sha_pkg::t_in_word  i_word,
    output logic               o_take,
    output logic               o_empty,
    output sha_pkg::t_out_word o_word,
    input  logic               i_pop
);
    import sha_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LEN   = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [31:0] r_h [8];
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [5:0]  r_pos;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oi;
    logic        r_final;   // current compression is the last of the message
    logic        r_eom;     // padding still to add after this compression

    logic [31:0] s0, s1, wnew, big0, big1, ch, maj, t1, t2;
    logic [31:0] wcur;

    assign wcur = r_w[0];
    always_comb begin
        s0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wnew = s1 + r_w[9] + s0 + r_w[0];
        big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1   = r_v[7] + big1 + ch + RoundK[r_rnd] + wcur;
        t2   = big0 + maj;
    end

    assign o_take  = (r_state == S_IDLE);
    assign o_empty = (r_state != S_OUT);
    assign o_word  = '{digest_word: r_h[r_oi], word_index: r_oi,
                       last_word: (r_oi == 3'd7)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
            r_rnd   <= '0;
            r_oi    <= '0;
            r_final <= 1'b0;
            r_eom   <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
            for (int i = 0; i < 16; i++) r_w[i] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_word.has_byte) begin
                            r_w[r_pos[5:2]] <= r_w[r_pos[5:2]] |
                                ({24'd0, i_word.data_byte} << (5'd24 - {r_pos[1:0], 3'd0}));
                            r_len <= r_len + 64'd8;
                            r_pos <= r_pos + 6'd1;
                        end
                        if (i_word.has_byte && r_pos == 6'd63) begin
                            // full block: compress first, pad afterward if needed
                            r_eom   <= i_word.end_of_message;
                            r_final <= 1'b0;
                            r_rnd   <= '0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            r_state <= S_ROUND;
                        end else if (i_word.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_w[r_pos[5:2]] <= r_w[r_pos[5:2]] |
                        (PadWord >> {r_pos[1:0], 3'd0});
                    r_eom <= 1'b0;
                    r_rnd <= '0;
                    if (r_pos >= 6'd56) begin
                        r_final <= 1'b0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_state <= S_ROUND;
                    end else begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_w[14] <= r_len[63:32];
                    r_w[15] <= r_len[31:0];
                    r_final <= 1'b1;
                    r_rnd   <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    // advance schedule window and working variables one round
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wnew;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    for (int i = 0; i < 16; i++) r_w[i] <= '0;
                    r_pos <= '0;
                    if (r_final) begin
                        r_oi    <= '0;
                        r_state <= S_OUT;
                    end else if (r_eom) begin
                        r_state <= S_PAD;
                    end else if (r_pos >= 6'd56) begin
                        // pad spilled into its own block: length goes in a fresh one
                        r_state <= S_LEN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_pop) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
                            r_len   <= '0;
                            r_final <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte-stream hasher: input queue and hashing core.
// A pushed word is registered in the queue before the core sees it; the core takes words only while idle.
// A full block is then compressed in 64 rounds, one per cycle, plus the chaining add.
// Finalization pads and appends the length, with one more compression when the pad spills
// into an extra block, then eight digest words, one per pop. A four-entry queue buffers input.
// Synchronous active-low reset restores the initial hash, clears length and block.
module sha256_byte_stream_hasher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sha_pkg::t_in_word  i_word,
    output logic               empty,
    input  logic               pop,
    output sha_pkg::t_out_word o_word
);
    import sha_pkg::*;

    logic     q_valid, q_take;
    t_in_word q_word;

    sha_in_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(i_word),
        .o_full(full), .o_valid(q_valid), .o_word(q_word), .i_take(q_take)
    );

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_word(q_word),
        .o_take(q_take), .o_empty(empty), .o_word(o_word), .i_pop(pop)
    );
endmodule

>>> sim/tb_sha256_byte_stream_hasher_unit.sv
// Self-checking testbench for the SHA-256 byte-stream hasher.
`timescale 1ns / 100ps

module tb_sha256_byte_stream_hasher_unit;
    import sha_pkg::*;

    localparam int unsigned WatchdogLimit = 20000;
    localparam int unsigned DrainCycles   = 300;
    localparam int unsigned MsgLens [7]   = '{55, 56, 1, 63, 0, 64, 2};

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in_word   i_word;
    logic       empty;
    logic       pop;
    t_out_word  o_word;

    sha256_byte_stream_hasher_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (i_word),
        .empty   (empty),
        .pop     (pop),
        .o_word  (o_word)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Hash state of the predictor.
    logic [31:0] hash_chain [8];
    logic [31:0] msg_block  [16];
    logic [5:0]  fill_count;
    logic [63:0] msg_bits;

    t_in_word  pending_words [$];
    t_out_word digest_fifo   [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_off_cycles;
    int unsigned quiet_cycles;
    int unsigned error_count;
    bit          stim_done;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_message();
        for (int i = 0; i < 8; i++) hash_chain[i] = InitHash[i];
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        fill_count = '0;
        msg_bits   = '0;
    endtask

    task automatic compress_message_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, ch, mj;
        for (int t = 0; t < 16; t++) w[t] = msg_block[t];
        for (int t = 16; t < 64; t++) begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
        for (int t = 0; t < 64; t++) begin
            s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t1 = v[7] + s1 + ch + RoundK[t] + w[t];
            t2 = s0 + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        fill_count = '0;
    endtask

    task automatic insert_byte(input logic [7:0] b);
        msg_block[fill_count[5:2]] |= {24'h0, b} << (24 - 8 * fill_count[1:0]);
    endtask

    task automatic predict_digest(input t_in_word w);
        t_out_word r;
        if (w.has_byte) begin
            insert_byte(w.data_byte);
            msg_bits   += 64'd8;
            fill_count += 6'd1;
            if (fill_count == 6'd0) compress_message_block();
        end
        if (w.end_of_message) begin
            insert_byte(8'h80);
            if (fill_count >= 6'd56) compress_message_block();
            msg_block[14] = msg_bits[63:32];
            msg_block[15] = msg_bits[31:0];
            compress_message_block();
            for (int k = 0; k < 8; k++) begin
                r.digest_word = hash_chain[k];
                r.word_index  = 3'(k);
                r.last_word   = (k == 7);
                digest_fifo.push_back(r);
            end
            clear_message();
        end
    endtask

    // Driver: offer the next pending word, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_digest(i_word);
                void'(pending_words.pop_front());
            end
            if ((!push || !full) && pending_words.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                // index 0 after the pop above is the next word
                push   <= 1'b1;
                i_word <= pending_words[0];
            end else if (!push || !full) begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: pop results, compare against predicted digest words.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (digest_fifo.size() == 0) begin
                    $display("%0t unexpected word: expected none actual %h/%0d/%0b", $time,
                             o_word.digest_word, o_word.word_index, o_word.last_word);
                    error_count++;
                end else begin
                    exp_w = digest_fifo.pop_front();
                    if (o_word !== exp_w) begin
                        $display("%0t mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                                 $time, exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                                 o_word.digest_word, o_word.word_index, o_word.last_word);
                        error_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("[sha256_byte_stream_hasher_unit] ERROR");
            $finish;
        end else if (!stim_done) begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_word mk(input logic [7:0] b, input bit h, input bit e);
        t_in_word w;
        w.data_byte = b;
        w.has_byte = h;
        w.end_of_message = e;
        return w;
    endfunction

    task automatic queue_message(input int unsigned len, input bit final_with_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                pending_words.push_back(mk(8'($urandom), 1'b0, 1'b0));
            pending_words.push_back(mk(8'($urandom), 1'b1, 1'b0));
        end
        pending_words.push_back(mk(8'($urandom), final_with_byte, 1'b1));
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || push || digest_fifo.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned n;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_word = '0;
        send_idle_pct = 30;
        recv_idle_pct = 49;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        error_count = 0;
        stim_done = 1'b0;
        clear_message();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, ignored bytes, extreme bytes, short messages.
        pending_words.push_back(mk(8'hff, 1'b0, 1'b0));
        pending_words.push_back(mk(8'h00, 1'b0, 1'b1));
        pending_words.push_back(mk(8'h00, 1'b1, 1'b0));
        pending_words.push_back(mk(8'hff, 1'b1, 1'b0));
        pending_words.push_back(mk(8'haa, 1'b0, 1'b0));
        pending_words.push_back(mk(8'h55, 1'b1, 1'b1));
        pending_words.push_back(mk(8'h61, 1'b1, 1'b1));
        wait_drained();

        // Long hold-off on the receiver while the sender keeps offering.
        hold_off_cycles = 600;
        queue_message(3, 1'b1);
        queue_message(12, 1'b0);
        wait_drained();

        // Random messages: block boundaries and short messages.
        n = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 49 : 0;
            recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 30 : 0;
            for (int m = 0; m < 7; m++) begin
                if (ph == 0) queue_message(MsgLens[m], 1'($urandom_range(1)));
                else queue_message($urandom_range(8), 1'($urandom_range(1)));
            end
            wait_drained();
        end

        stim_done = 1'b1;
        repeat (DrainCycles) @(posedge i_clk);
        if (error_count == 0 && digest_fifo.size() == 0)
            $display("[sha256_byte_stream_hasher_unit] OK");
        else
            $display("[sha256_byte_stream_hasher_unit] ERROR");
        $finish;
    end

endmodule
